// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, off during reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: label");
// Next-cycle implication checked every clock, off during reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: label");
`endif

// ===== hdl/mfde_pkg.sv =====
// Package for the framebuffer draw engine: constants, op codes, states, glyph table.
package mfde_pkg;
   localparam int ScreenWidthDef  = 128;
   localparam int ScreenHeightDef = 32;
   localparam int PageRows        = 8;
   localparam int GlyphRows       = 5;
   localparam int GlyphCols       = 5;

   typedef enum logic [2:0] {
      OP_PIXEL = 3'd0,
      OP_LINE  = 3'd1,
      OP_RECT  = 3'd2,
      OP_GLYPH = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_MODIFY,
      ST_READ,
      ST_OUT
   } state_type;

   // Row masks of one glyph; bit c of a row is column c.
   function automatic logic [4:0] glyph_row(input logic [7:0] code, input logic [2:0] row);
      logic [24:0] g;
      case (code)
         8'h61: g = {5'h09, 5'h09, 5'h0F, 5'h09, 5'h06};
         8'h62: g = {5'h07, 5'h09, 5'h07, 5'h09, 5'h07};
         8'h63: g = {5'h0E, 5'h01, 5'h01, 5'h01, 5'h0E};
         8'h64: g = {5'h07, 5'h09, 5'h09, 5'h09, 5'h07};
         8'h65: g = {5'h0F, 5'h01, 5'h07, 5'h01, 5'h0F};
         8'h66: g = {5'h01, 5'h01, 5'h07, 5'h01, 5'h0F};
         8'h67: g = {5'h0E, 5'h09, 5'h0D, 5'h01, 5'h0E};
         8'h68: g = {5'h09, 5'h09, 5'h0F, 5'h09, 5'h09};
         8'h69: g = {5'h02, 5'h02, 5'h02, 5'h02, 5'h02};
         8'h6A: g = {5'h06, 5'h09, 5'h08, 5'h08, 5'h08};
         8'h6B: g = {5'h09, 5'h05, 5'h03, 5'h05, 5'h09};
         8'h6C: g = {5'h07, 5'h01, 5'h01, 5'h01, 5'h01};
         8'h6D: g = {5'h11, 5'h11, 5'h15, 5'h1B, 5'h11};
         8'h6E: g = {5'h09, 5'h09, 5'h0D, 5'h0B, 5'h09};
         8'h6F: g = {5'h06, 5'h09, 5'h09, 5'h09, 5'h06};
         8'h70: g = {5'h01, 5'h01, 5'h07, 5'h09, 5'h07};
         8'h71: g = {5'h0E, 5'h0D, 5'h09, 5'h09, 5'h06};
         8'h72: g = {5'h09, 5'h05, 5'h07, 5'h09, 5'h07};
         8'h73: g = {5'h07, 5'h08, 5'h06, 5'h01, 5'h0E};
         8'h74: g = {5'h02, 5'h02, 5'h02, 5'h02, 5'h07};
         8'h75: g = {5'h0F, 5'h09, 5'h09, 5'h09, 5'h09};
         8'h76: g = {5'h02, 5'h05, 5'h05, 5'h05, 5'h05};
         8'h77: g = {5'h02, 5'h15, 5'h11, 5'h11, 5'h11};
         8'h78: g = {5'h05, 5'h05, 5'h02, 5'h05, 5'h05};
         8'h79: g = {5'h02, 5'h02, 5'h07, 5'h05, 5'h05};
         8'h7A: g = {5'h0F, 5'h02, 5'h04, 5'h08, 5'h0F};
         8'h3A: g = {5'h03, 5'h03, 5'h00, 5'h03, 5'h03};
         8'h20: g = 25'd0;
         default: g = {5{5'h0F}};
      endcase
      case (row)
         3'd0: glyph_row = g[4:0];
         3'd1: glyph_row = g[9:5];
         3'd2: glyph_row = g[14:10];
         3'd3: glyph_row = g[19:15];
         3'd4: glyph_row = g[24:20];
         default: glyph_row = 5'd0;
      endcase
   endfunction
endpackage

// ===== hdl/mono_framebuffer_draw_engine.sv =====
// Top level of the page-organized one-bit framebuffer draw engine.
// Draw engine over a SCREEN_WIDTH x SCREEN_HEIGHT one-bit framebuffer held in one
// synchronous byte memory (byte = x*pages + y/8, bit = y mod 8). After reset a
// clearing pass writes every byte (SCREEN_WIDTH*pages, 512 by default) to zero, one
// per cycle; no request is taken meanwhile. One command is worked at a time and the
// next request is taken in the idle cycle after it. Every pixel of a command goes
// through ISSUE (address and read), then MODIFY (modify and write back); off-screen
// pixels and blank glyph cells pass through the same states without a memory access.
// A line walks its pixels, a rectangle the pixels of its four sides (corners counted
// on each side), a glyph its 25 cells; a diagonal line or an unused code draws
// nothing. A read passes READ and OUT and shows its response in the same cycle as
// the engine is idle again; while the previous response still waits, the read holds
// until that one is taken.
module mono_framebuffer_draw_engine #(
   parameter int SCREEN_WIDTH  = mfde_pkg::ScreenWidthDef,
   parameter int SCREEN_HEIGHT = mfde_pkg::ScreenHeightDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[2:0], first_x[10:3], first_y[16:11], second_x[24:17], second_y[30:25],
   // pixel_on[31], char_code[39:32], byte_index[48:40], zero fill to 56
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_byte[7:0]
   output logic [7:0]  rsp_tdata
);
   localparam int Pages      = (SCREEN_HEIGHT + mfde_pkg::PageRows - 1) / mfde_pkg::PageRows;
   localparam int StoreBytes = SCREEN_WIDTH * Pages;
   localparam int AddrW      = $clog2(StoreBytes);

   // Request fields
   logic [2:0] op;
   logic [7:0] fx, sx, code;
   logic [5:0] fy, sy;
   logic       pon;
   logic [8:0] bidx;
   logic [AddrW+8:0] bidx_wide;
   assign op   = req_tdata[2:0];
   assign fx   = req_tdata[10:3];
   assign fy   = req_tdata[16:11];
   assign sx   = req_tdata[24:17];
   assign sy   = req_tdata[30:25];
   assign pon  = req_tdata[31];
   assign code = req_tdata[39:32];
   assign bidx = req_tdata[48:40];
   assign bidx_wide = {{AddrW{1'b0}}, bidx};

   logic [7:0] mem [StoreBytes];
   logic [7:0] rdata_ff;

   mfde_pkg::state_type state_ff, state_in;
   logic [AddrW:0] clr_ff, clr_in;
   logic [2:0] op_ff, op_in;
   logic [1:0] side_ff, side_in;      // rectangle side, or 0 for a plain line
   logic [7:0] cx_ff, cx_in, ex_ff, ex_in;
   logic [5:0] cy_ff, cy_in, ey_ff, ey_in;
   logic [7:0] x0_ff, x0_in, x1_ff, x1_in;
   logic [5:0] y0_ff, y0_in, y1_ff, y1_in;
   logic       on_ff, on_in, rdzero_ff, rdzero_in;
   logic [7:0] code_ff, code_in;
   logic [2:0] gr_ff, gr_in, gc_ff, gc_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic [7:0] out_ff, out_in;
   logic       mem_we, mem_re;
   logic [7:0] mem_wd;
   logic [AddrW-1:0] mem_wa;

   // Current pixel
   logic [8:0] px;
   logic [6:0] py;
   logic       pvis, gbit, last, hz;
   logic [4:0] grow;
   logic [AddrW+8:0] pidx;
   always_comb begin
      grow = mfde_pkg::glyph_row(code_ff, gr_ff);
      gbit = grow[gc_ff];
      if (op_ff == mfde_pkg::OP_GLYPH) begin
         px = {1'b0, x0_ff} + {6'd0, gc_ff};
         py = {1'b0, y0_ff} + {4'd0, gr_ff};
      end else begin
         px = {1'b0, cx_ff};
         py = {1'b0, cy_ff};
      end
      pvis = (px < 9'(SCREEN_WIDTH)) && (py < 7'(SCREEN_HEIGHT))
             && (op_ff != mfde_pkg::OP_GLYPH || gbit);
      pidx = (AddrW+9)'(px) * (AddrW+9)'(Pages) + (AddrW+9)'(py >> 3);
      hz = (cy_ff == ey_ff);
      if (op_ff == mfde_pkg::OP_GLYPH) last = (gr_ff == 3'd4) && (gc_ff == 3'd4);
      else last = (cx_ff == ex_ff) && (cy_ff == ey_ff);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff; clr_in = clr_ff; op_in = op_ff; side_in = side_ff;
      cx_in = cx_ff; cy_in = cy_ff; ex_in = ex_ff; ey_in = ey_ff;
      x0_in = x0_ff; y0_in = y0_ff; x1_in = x1_ff; y1_in = y1_ff;
      on_in = on_ff; code_in = code_ff; gr_in = gr_ff; gc_in = gc_ff;
      addr_in = addr_ff; out_in = out_ff; rdzero_in = rdzero_ff;
      mem_we = 1'b0; mem_re = 1'b0; mem_wd = 8'd0; mem_wa = clr_ff[AddrW-1:0];
      req_tready = 1'b0;
      case (state_ff)
         mfde_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AddrW+1)'(StoreBytes - 1)) state_in = mfde_pkg::ST_IDLE;
         end
         mfde_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in = op; x0_in = fx; y0_in = fy; x1_in = sx; y1_in = sy;
               on_in = pon; code_in = code; gr_in = 3'd0; gc_in = 3'd0;
               side_in = 2'd0;
               // plain line and first rectangle side (left edge)
               cx_in = fx; ex_in = (op == mfde_pkg::OP_LINE) ? sx : fx;
               cy_in = fy; ey_in = sy;
               addr_in = bidx_wide[AddrW-1:0];
               rdzero_in = ({23'd0, bidx} >= 32'(StoreBytes));
               case (op)
                  mfde_pkg::OP_PIXEL: begin
                     on_in = pon; ex_in = fx; ey_in = fy; state_in = mfde_pkg::ST_ISSUE;
                  end
                  mfde_pkg::OP_LINE: begin
                     if (fx != sx && fy != sy) state_in = mfde_pkg::ST_IDLE;
                     else state_in = mfde_pkg::ST_ISSUE;
                     // walk from the lower end
                     if (fy == sy) begin
                        cx_in = (fx < sx) ? fx : sx; ex_in = (fx < sx) ? sx : fx;
                     end else begin
                        cy_in = (fy < sy) ? fy : sy; ey_in = (fy < sy) ? sy : fy;
                     end
                  end
                  mfde_pkg::OP_RECT: begin
                     cy_in = (fy < sy) ? fy : sy; ey_in = (fy < sy) ? sy : fy;
                     state_in = mfde_pkg::ST_ISSUE;
                  end
                  mfde_pkg::OP_GLYPH: begin
                     on_in = 1'b1; state_in = mfde_pkg::ST_ISSUE;
                  end
                  mfde_pkg::OP_READ: state_in = mfde_pkg::ST_READ;
                  default: state_in = mfde_pkg::ST_IDLE;
               endcase
            end
         end
         mfde_pkg::ST_ISSUE: begin
            addr_in = pidx[AddrW-1:0];
            if (pvis) begin
               mem_re = 1'b1;
               state_in = mfde_pkg::ST_MODIFY;
            end else begin
               state_in = mfde_pkg::ST_MODIFY;
            end
         end
         mfde_pkg::ST_MODIFY: begin
            mem_wa = addr_ff;
            if (pvis) begin
               mem_we = 1'b1;
               mem_wd = on_ff ? (rdata_ff | (8'd1 << cy_ff[2:0] + 3'd0))
                              : (rdata_ff & ~(8'd1 << cy_ff[2:0]));
               if (op_ff == mfde_pkg::OP_GLYPH) begin
                  mem_wd = rdata_ff | (8'd1 << py[2:0]);
               end
            end
            state_in = mfde_pkg::ST_ISSUE;
            // advance the walk
            if (op_ff == mfde_pkg::OP_GLYPH) begin
               if (last) state_in = mfde_pkg::ST_IDLE;
               else if (gc_ff == 3'd4) begin
                  gc_in = 3'd0; gr_in = gr_ff + 3'd1;
               end else gc_in = gc_ff + 3'd1;
            end else if (!last) begin
               if (hz) cx_in = cx_ff + 8'd1;
               else cy_in = cy_ff + 6'd1;
            end else if (op_ff != mfde_pkg::OP_RECT || side_ff == 2'd3) begin
               state_in = mfde_pkg::ST_IDLE;
            end else begin
               side_in = side_ff + 2'd1;
               case (side_ff)
                  2'd0: begin  // top edge at first_y
                     cx_in = (x0_ff < x1_ff) ? x0_ff : x1_ff;
                     ex_in = (x0_ff < x1_ff) ? x1_ff : x0_ff;
                     cy_in = y0_ff; ey_in = y0_ff;
                  end
                  2'd1: begin  // right edge at second_x
                     cx_in = x1_ff; ex_in = x1_ff;
                     cy_in = (y0_ff < y1_ff) ? y0_ff : y1_ff;
                     ey_in = (y0_ff < y1_ff) ? y1_ff : y0_ff;
                  end
                  default: begin  // bottom edge at second_y
                     cx_in = (x0_ff < x1_ff) ? x0_ff : x1_ff;
                     ex_in = (x0_ff < x1_ff) ? x1_ff : x0_ff;
                     cy_in = y1_ff; ey_in = y1_ff;
                  end
               endcase
            end
         end
         mfde_pkg::ST_READ: begin
            mem_re = 1'b1;
            state_in = mfde_pkg::ST_OUT;
         end
         mfde_pkg::ST_OUT: begin
            if (!rsp_tvalid || rsp_tready) begin
               out_in = rdzero_ff ? 8'd0 : rdata_ff;
               state_in = mfde_pkg::ST_IDLE;
            end
         end
         default: state_in = mfde_pkg::ST_IDLE;
      endcase
   end

   // Response register
   logic rspv_ff, rspv_in;
   always_comb begin
      rspv_in = rspv_ff;
      if (rsp_tready) rspv_in = 1'b0;
      if (state_ff == mfde_pkg::ST_OUT && (!rspv_ff || rsp_tready)) rspv_in = 1'b1;
   end
   assign rsp_tvalid = rspv_ff;
   assign rsp_tdata  = out_ff;

   // Frame memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rdata_ff <= mem[addr_in];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfde_pkg::ST_CLEAR;
         clr_ff   <= '0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rspv_ff  <= rspv_in;
      end
   end

   // Command registers
   always_ff @(posedge clock) begin
      op_ff <= op_in; side_ff <= side_in; cx_ff <= cx_in; cy_ff <= cy_in;
      ex_ff <= ex_in; ey_ff <= ey_in; x0_ff <= x0_in; y0_ff <= y0_in;
      x1_ff <= x1_in; y1_ff <= y1_in; on_ff <= on_in; code_ff <= code_in;
      gr_ff <= gr_in; gc_ff <= gc_in; addr_ff <= addr_in; out_ff <= out_in;
      rdzero_ff <= rdzero_in;
   end
endmodule

// ===== hdl/mfde_checker.sv =====
// Port-level checker for the draw engine, bound to the top level.
`include "assert_macros.svh"
module mfde_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [55:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);
   logic rd_acc;
   assign rd_acc = req_tvalid && req_tready && req_tdata[2:0] == mfde_pkg::OP_READ;
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `CHK_NEXT(a_busy_after_read, clock, reset, rd_acc, !req_tready)
   `CHK_NEXT(a_no_rsp_early, clock, reset, rd_acc && !rsp_tvalid, !rsp_tvalid)
endmodule

bind mono_framebuffer_draw_engine mfde_checker u_mfde_checker (.*);

// ===== sim/tb_mono_framebuffer_draw_engine.sv =====
// Self-checking testbench for the page-organized one-bit framebuffer draw engine.
`timescale 1ns / 100ps

module tb_mono_framebuffer_draw_engine;
   localparam int Width      = 128;
   localparam int Height     = 32;
   localparam int Pages      = (Height + mfde_pkg::PageRows - 1) / mfde_pkg::PageRows;
   localparam int StoreBytes = Width * Pages;
   localparam int CycleLimit = 2000000;
   localparam int DrainWait  = 2000;
   localparam int HoldCycles = 3000;

   // unused operation codes, not in the package enum
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // operation, first_x, first_y, second_x, second_y, pixel_on, char_code,
   // byte_index, zero fill
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // read_byte
   logic [7:0]  rsp_tdata;

   logic [55:0] pending_requests[$];
   logic [7:0]  read_bytes_due[$];
   logic [7:0]  shadow_frame[StoreBytes];
   int          sender_idle_pct;
   int          receiver_stall_pct;
   bit          hold_go;
   bit          hold_done;
   int          hold_count;
   int          error_count;
   int          cycle_count;

   mono_framebuffer_draw_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock, 2 ns period
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // glyph rows, bit c of a row is column c; row 0 in the low bits
   function automatic logic [24:0] glyph_bits(input logic [7:0] code);
      case (code)
         "a": glyph_bits = {5'h09, 5'h09, 5'h0F, 5'h09, 5'h06};
         "b": glyph_bits = {5'h07, 5'h09, 5'h07, 5'h09, 5'h07};
         "c": glyph_bits = {5'h0E, 5'h01, 5'h01, 5'h01, 5'h0E};
         "d": glyph_bits = {5'h07, 5'h09, 5'h09, 5'h09, 5'h07};
         "e": glyph_bits = {5'h0F, 5'h01, 5'h07, 5'h01, 5'h0F};
         "f": glyph_bits = {5'h01, 5'h01, 5'h07, 5'h01, 5'h0F};
         "g": glyph_bits = {5'h0E, 5'h09, 5'h0D, 5'h01, 5'h0E};
         "h": glyph_bits = {5'h09, 5'h09, 5'h0F, 5'h09, 5'h09};
         "i": glyph_bits = {5'h02, 5'h02, 5'h02, 5'h02, 5'h02};
         "j": glyph_bits = {5'h06, 5'h09, 5'h08, 5'h08, 5'h08};
         "k": glyph_bits = {5'h09, 5'h05, 5'h03, 5'h05, 5'h09};
         "l": glyph_bits = {5'h07, 5'h01, 5'h01, 5'h01, 5'h01};
         "m": glyph_bits = {5'h11, 5'h11, 5'h15, 5'h1B, 5'h11};
         "n": glyph_bits = {5'h09, 5'h09, 5'h0D, 5'h0B, 5'h09};
         "o": glyph_bits = {5'h06, 5'h09, 5'h09, 5'h09, 5'h06};
         "p": glyph_bits = {5'h01, 5'h01, 5'h07, 5'h09, 5'h07};
         "q": glyph_bits = {5'h0E, 5'h0D, 5'h09, 5'h09, 5'h06};
         "r": glyph_bits = {5'h09, 5'h05, 5'h07, 5'h09, 5'h07};
         "s": glyph_bits = {5'h07, 5'h08, 5'h06, 5'h01, 5'h0E};
         "t": glyph_bits = {5'h02, 5'h02, 5'h02, 5'h02, 5'h07};
         "u": glyph_bits = {5'h0F, 5'h09, 5'h09, 5'h09, 5'h09};
         "v": glyph_bits = {5'h02, 5'h05, 5'h05, 5'h05, 5'h05};
         "w": glyph_bits = {5'h02, 5'h15, 5'h11, 5'h11, 5'h11};
         "x": glyph_bits = {5'h05, 5'h05, 5'h02, 5'h05, 5'h05};
         "y": glyph_bits = {5'h02, 5'h02, 5'h07, 5'h05, 5'h05};
         "z": glyph_bits = {5'h0F, 5'h02, 5'h04, 5'h08, 5'h0F};
         ":": glyph_bits = {5'h03, 5'h03, 5'h00, 5'h03, 5'h03};
         " ": glyph_bits = 25'd0;
         default: glyph_bits = {5{5'h0F}};
      endcase
   endfunction

   // one pixel into the shadow frame; off-screen is dropped
   task automatic plot(input int x, input int y, input bit on);
      int idx;
      if (x >= Width || y >= Height) return;
      idx = x * Pages + y / mfde_pkg::PageRows;
      shadow_frame[idx][y % mfde_pkg::PageRows] = on;
   endtask

   // horizontal or vertical, inclusive; diagonal draws nothing
   task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                            input bit on);
      int lo;
      int hi;
      if (y0 == y1) begin
         lo = (x0 < x1) ? x0 : x1;
         hi = (x0 < x1) ? x1 : x0;
         for (int k = lo; k <= hi; k++) plot(k, y0, on);
      end else if (x0 == x1) begin
         lo = (y0 < y1) ? y0 : y1;
         hi = (y0 < y1) ? y1 : y0;
         for (int k = lo; k <= hi; k++) plot(x0, k, on);
      end
   endtask

   // apply one accepted request to the shadow frame
   task automatic update_frame(input logic [55:0] w);
      logic [2:0]  op;
      int          x0;
      int          y0;
      int          x1;
      int          y1;
      bit          on;
      logic [24:0] g;
      int          idx;
      op  = w[2:0];
      x0  = int'(w[10:3]);
      y0  = int'(w[16:11]);
      x1  = int'(w[24:17]);
      y1  = int'(w[30:25]);
      on  = w[31];
      idx = int'(w[48:40]);
      case (op)
         mfde_pkg::OP_PIXEL: plot(x0, y0, on);
         mfde_pkg::OP_LINE:  draw_line(x0, y0, x1, y1, on);
         mfde_pkg::OP_RECT: begin
            draw_line(x0, y0, x0, y1, on);
            draw_line(x0, y0, x1, y0, on);
            draw_line(x1, y0, x1, y1, on);
            draw_line(x0, y1, x1, y1, on);
         end
         mfde_pkg::OP_GLYPH: begin
            g = glyph_bits(w[39:32]);
            for (int r = 0; r < mfde_pkg::GlyphRows; r++)
               for (int c = 0; c < mfde_pkg::GlyphCols; c++)
                  if (g[r * mfde_pkg::GlyphCols + c]) plot(x0 + c, y0 + r, 1'b1);
         end
         mfde_pkg::OP_READ:
            read_bytes_due.push_back(idx < StoreBytes ? shadow_frame[idx] : 8'd0);
         default: ;
      endcase
   endtask

   function automatic logic [55:0] pack(input logic [2:0] op, input logic [7:0] x0,
                                        input logic [5:0] y0, input logic [7:0] x1,
                                        input logic [5:0] y1, input logic on,
                                        input logic [7:0] code, input logic [8:0] idx);
      pack = {7'd0, idx, code, on, y1, x1, y0, x0, op};
   endfunction

   task automatic add(input logic [2:0] op, input int x0, input int y0, input int x1,
                      input int y1, input bit on, input int code, input int idx);
      pending_requests.push_back(pack(op, 8'(x0), 6'(y0), 8'(x1), 6'(y1), on, 8'(code),
                                      9'(idx)));
   endtask

   // one random request; mostly on-screen with short lines, some noise
   task automatic add_random();
      int  pick;
      int  x0;
      int  y0;
      int  x1;
      int  y1;
      int  len;
      logic [55:0] w;
      pick = $urandom_range(0, 99);
      x0 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 127);
      y0 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 31);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 140) : $urandom_range(0, 12);
      x1 = $urandom_range(0, 1) ? x0 + len : x0 - len;
      y1 = $urandom_range(0, 1) ? y0 + len : y0 - len;
      x1 = (x1 < 0) ? 0 : (x1 > 255 ? 255 : x1);
      y1 = (y1 < 0) ? 0 : (y1 > 63 ? 63 : y1);
      w = 56'({$urandom, $urandom});
      w[55:49] = '0;
      w[10:3]  = 8'(x0);
      w[16:11] = 6'(y0);
      if (pick < 15) begin
         w[2:0] = mfde_pkg::OP_PIXEL;
      end else if (pick < 35) begin
         w[2:0] = mfde_pkg::OP_LINE;
         case ($urandom_range(0, 5))
            0, 1, 2: begin w[24:17] = 8'(x1); w[30:25] = 6'(y0); end
            3, 4:    begin w[24:17] = 8'(x0); w[30:25] = 6'(y1); end
            default: ;
         endcase
      end else if (pick < 45) begin
         w[2:0] = mfde_pkg::OP_RECT;
         w[24:17] = 8'(x0 + (($urandom_range(0, 1) ? len : -len) % 10));
         w[30:25] = 6'(y1);
         if ($urandom_range(0, 9) != 0 && len > 10)
            w[24:17] = 8'(x0 + $urandom_range(0, 9));
      end else if (pick < 58) begin
         w[2:0] = mfde_pkg::OP_GLYPH;
         if ($urandom_range(0, 3) != 0) w[39:32] = 8'($urandom_range("a", "z"));
      end else if (pick < 96) begin
         w[2:0] = mfde_pkg::OP_READ;
      end else begin
         w[2:0] = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      pending_requests.push_back(w);
   endtask

   // request driver
   always @(posedge clock) begin
      logic go;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) update_frame(req_tdata);
         if (!req_tvalid || req_tready) begin
            go = pending_requests.size() != 0 &&
                 $urandom_range(0, 99) >= sender_idle_pct;
            if (go) req_tdata <= pending_requests.pop_front();
            req_tvalid <= go;
         end
      end
   end

   // response side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_count <= 0;
         hold_done  <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done  <= 1'b1;
         hold_count <= HoldCycles;
         rsp_tready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= receiver_stall_pct;
      end
   end

   // response monitor
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (read_bytes_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %02h",
                     $realtime, rsp_tdata);
            error_count++;
         end else begin
            want = read_bytes_due.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t: read_byte mismatch, expected %02h, actual %02h",
                        $realtime, want, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic drain();
      while (pending_requests.size() != 0) @(posedge clock);
   endtask

   initial begin
      error_count        = 0;
      cycle_count        = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_go            = 1'b0;
      for (int i = 0; i < StoreBytes; i++) shadow_frame[i] = 8'd0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, off-screen, lines both ways, rectangles, glyphs, unused codes, reads
      add(mfde_pkg::OP_READ,  0, 0, 0, 0, 0, 0, 0);
      add(mfde_pkg::OP_PIXEL, 0, 0, 255, 63, 1, 255, 511);
      add(mfde_pkg::OP_PIXEL, 127, 31, 0, 0, 1, 0, 0);
      add(mfde_pkg::OP_PIXEL, 128, 0, 0, 0, 1, 0, 0);
      add(mfde_pkg::OP_PIXEL, 0, 32, 0, 0, 1, 0, 0);
      add(mfde_pkg::OP_PIXEL, 255, 63, 0, 0, 1, 0, 0);
      add(mfde_pkg::OP_READ,  0, 0, 0, 0, 0, 0, 511);
      add(mfde_pkg::OP_LINE,  20, 9, 3, 9, 1, 0, 0);
      add(mfde_pkg::OP_LINE,  5, 30, 5, 2, 1, 0, 0);
      add(mfde_pkg::OP_LINE,  9, 9, 9, 9, 1, 0, 0);
      add(mfde_pkg::OP_LINE,  40, 1, 50, 6, 1, 0, 0);
      add(mfde_pkg::OP_LINE,  120, 4, 255, 4, 1, 0, 0);
      add(mfde_pkg::OP_PIXEL, 10, 9, 0, 0, 0, 0, 0);
      add(mfde_pkg::OP_RECT,  60, 2, 70, 20, 1, 0, 0);
      add(mfde_pkg::OP_RECT,  64, 5, 64, 5, 0, 0, 0);
      add(mfde_pkg::OP_GLYPH, 80, 0, 0, 0, 0, "a", 0);
      add(mfde_pkg::OP_GLYPH, 86, 0, 0, 0, 0, "m", 0);
      add(mfde_pkg::OP_GLYPH, 92, 0, 0, 0, 0, "w", 0);
      add(mfde_pkg::OP_GLYPH, 98, 8, 0, 0, 0, ":", 0);
      add(mfde_pkg::OP_GLYPH, 100, 8, 0, 0, 0, " ", 0);
      add(mfde_pkg::OP_GLYPH, 125, 29, 0, 0, 0, "Z", 0);
      add(OP_SPARE_LO, 1, 1, 1, 1, 1, 0, 0);
      add(OP_SPARE_MID, 2, 2, 2, 2, 1, 0, 0);
      add(OP_SPARE_HI, 3, 3, 3, 3, 1, 0, 0);
      for (int i = 320; i < 328; i++) add(mfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, i);
      drain();

      // random phases with different idling, long hold-off in the third
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; hold_go = 1'b1; end
            default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
         endcase
         repeat (150) add_random();
         drain();
      end
      // reads of random bytes across the whole frame
      for (int i = 0; i < 24; i++)
         add(mfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, $urandom_range(0, 511));
      drain();

      while (read_bytes_due.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
